// ===== design/dtm_pkg.sv =====
// Shared constants, types and codes for the die temperature monitor.
`timescale 1ns / 1ps
`default_nettype none

package dtm_pkg;

   // defaults for the top-level parameters
   localparam int DEF_SAMPLE_BITS  = 12;
   localparam int DEF_WARMUP_STEPS = 10;

   // warm-up countdown
   localparam int COUNT_W = 4;
   localparam logic [COUNT_W-1:0] LOAD_COUNT   = 4'd5;
   localparam logic [COUNT_W-1:0] SWITCH_COUNT = 4'd2;

   // fixed point: reference in Q.8, gain and offset in Q16
   localparam int REF_FRAC = 8;
   localparam int SCALE_W  = 25;
   localparam int QUO_W    = 26;   // quotient bits kept; larger saturates
   localparam int Q_FRAC   = 16;
   localparam logic [SCALE_W-1:0] SCALE_Q16  = 25'd32401392;   // 1.21 * 408.6
   localparam logic [QUO_W-1:0]   OFFSET_Q16 = 26'd18448384;   // 281.5

   localparam int TEMP_W = 8;
   localparam logic [TEMP_W-1:0] TEMP_MAX = 8'hFF;

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [TEMP_W-1:0] WARN_RESET  = 8'd75;
   localparam logic [TEMP_W-1:0] ERROR_RESET = 8'd85;

   typedef enum logic {
      REG_WARN  = 1'b0,
      REG_ERROR = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      ALARM_NONE    = 2'd0,
      ALARM_ERROR   = 2'd1,
      ALARM_WARN    = 2'd2,
      ALARM_CLEARED = 2'd3
   } alarm_type;

   // status of the scaling unit toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } scale_stat_type;

endpackage

`default_nettype wire

// ===== design/dtm_scale.sv =====
// Scaling unit: one multiply, then a bit-serial restoring divide by the reference.
`timescale 1ns / 1ps
`default_nettype none

module dtm_scale
   import dtm_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [SAMPLE_BITS-1:0]          sample,
   input  wire logic [SAMPLE_BITS+REF_FRAC-1:0] ref_level,
   output scale_stat_type                       stat,
   output logic      [TEMP_W-1:0]               temperature
);

   localparam int REF_W  = SAMPLE_BITS + REF_FRAC;
   localparam int PROD_W = SAMPLE_BITS + SCALE_W;
   localparam int NUM_W  = PROD_W + REF_FRAC;
   localparam int HI_W   = NUM_W - QUO_W;
   localparam int CNT_W  = $clog2(QUO_W);
   localparam int T_W    = QUO_W - Q_FRAC;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_CHECK,
      S_DIV,
      S_OUT
   } state_type;

   state_type               state_ff, state_in;
   logic [SAMPLE_BITS-1:0]  sample_ff, sample_in;
   logic [REF_W-1:0]        ref_ff, ref_in;
   logic [NUM_W-1:0]        num_ff, num_in;
   logic [REF_W-1:0]        rem_ff, rem_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    sat_ff, sat_in;

   logic [PROD_W-1:0]       prod;
   logic [HI_W-1:0]         num_hi;
   logic [REF_W:0]          trial;
   logic                    fits;
   logic [QUO_W-1:0]        diff;
   logic [T_W-1:0]          whole;

   assign prod   = PROD_W'(sample_ff) * PROD_W'(SCALE_Q16);
   assign num_hi = num_ff[NUM_W-1:QUO_W];
   // shared subtract/compare: one quotient bit per cycle
   assign trial  = {rem_ff, quo_ff[QUO_W-1]};
   assign fits   = trial >= {1'b0, ref_ff};
   assign diff   = quo_ff - OFFSET_Q16;
   assign whole  = diff[QUO_W-1:Q_FRAC];

   always_comb begin
      if (sat_ff) begin
         temperature = TEMP_MAX;
      end else if (quo_ff <= OFFSET_Q16) begin
         temperature = '0;
      end else if (|whole[T_W-1:TEMP_W]) begin
         temperature = TEMP_MAX;
      end else begin
         temperature = whole[TEMP_W-1:0];
      end
   end

   assign stat.busy = (state_ff != S_IDLE);
   assign stat.done = (state_ff == S_OUT);

   always_comb begin
      state_in  = state_ff;
      sample_in = sample_ff;
      ref_in    = ref_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      sat_in    = sat_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               sample_in = sample;
               ref_in    = ref_level;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            num_in   = {prod, {REF_FRAC{1'b0}}};
            state_in = S_CHECK;
         end
         S_CHECK: begin
            // quotient overflows QUO_W bits (or ref is zero) -> saturate
            sat_in   = REF_W'(num_hi) >= ref_ff;
            rem_in   = REF_W'(num_hi);
            quo_in   = num_ff[QUO_W-1:0];
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (fits) begin
               rem_in = REF_W'(trial - {1'b0, ref_ff});
            end else begin
               rem_in = trial[REF_W-1:0];
            end
            quo_in = {quo_ff[QUO_W-2:0], fits};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QUO_W - 1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      sample_ff <= sample_in;
      ref_ff    <= ref_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      sat_ff    <= sat_in;
   end

endmodule

`default_nettype wire

// ===== design/die_temperature_monitor_top.sv =====
// Top level of the die temperature monitor: warm-up, alarm, handshakes and registers.
`timescale 1ns / 1ps
`default_nettype none

// Die temperature monitor. Each transfer on the req_ channel carries one raw
// converter sample and yields exactly one transfer on the rsp_ channel. The
// first WARMUP_STEPS samples build the reference level (loaded at count 5,
// averaged halfway otherwise, switch_channel flagged at count 2). They report
// temperature 0 and pass from ST_IDLE through ST_DONE back to ST_IDLE. After
// warm-up each sample is scaled as sample / reference * 494.406 - 281.5,
// truncated and clamped to 0..255. The scaling unit runs one multiply step,
// one range check, 26 iterations of a one-bit-per-cycle restoring divider and
// one result step. The hand-off to the output register in ST_DONE and the
// return to ST_IDLE follow, without a pause while it is free. When the result
// channel stalls, a finished result waits in ST_DONE until the output register
// drains. req_stall is high for the whole of that work. A finished result sits
// in the output register so the next sample can be taken while it waits.
// The alarm is evaluated on every sample: error or warning is raised once and
// latched, and cleared when the temperature drops to the warn threshold or
// below. Thresholds live in an APB register file (warn at 0x0, error at 0x4)
// and may only be written while the block is idle.

module die_temperature_monitor_top
   import dtm_pkg::*;
#(
   parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
   parameter int WARMUP_STEPS = DEF_WARMUP_STEPS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // sample input
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [SAMPLE_BITS-1:0] req_sample,
   // temperature result
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic      [TEMP_W-1:0]      rsp_temperature,
   output logic                        rsp_calibrated,
   output logic                        rsp_switch_channel,
   output logic      [1:0]             rsp_alarm_event,
   // register file
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [CSR_DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);

   localparam int REF_W = SAMPLE_BITS + REF_FRAC;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCALE,
      ST_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [TEMP_W-1:0]   warn_ff, warn_in;
   logic [TEMP_W-1:0]   error_ff, error_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [REF_W-1:0]    ref_ff, ref_in;
   logic                latched_ff, latched_in;
   // result being assembled
   logic [TEMP_W-1:0]   res_temp_ff, res_temp_in;
   logic                res_cal_ff, res_cal_in;
   logic                res_sw_ff, res_sw_in;
   // output register
   logic                out_valid_ff, out_valid_in;
   logic [TEMP_W-1:0]   out_temp_ff, out_temp_in;
   logic                out_cal_ff, out_cal_in;
   logic                out_sw_ff, out_sw_in;
   alarm_type           out_alarm_ff, out_alarm_in;

   logic                req_take;
   logic                out_free;
   logic                out_load;
   logic                csr_write;
   reg_index_type       csr_index;
   logic [REF_W-1:0]    sample_ref;
   logic [REF_W:0]      ref_sum;
   logic                scale_start;
   scale_stat_type      scale_stat;
   logic [TEMP_W-1:0]   scale_temp;
   alarm_type           alarm_code;
   logic                alarm_next;

   // ---------------------------------------------------------------- CSRs
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[2]);

   always_comb begin
      case (csr_index)
         REG_WARN:  csr_prdata = CSR_DATA_W'(warn_ff);
         REG_ERROR: csr_prdata = CSR_DATA_W'(error_ff);
         default:   csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid & ~req_stall;
   // output register can take a result when empty or being drained this cycle
   assign out_free  = ~out_valid_ff | ~rsp_stall;
   assign out_load  = (state_ff == ST_DONE) & out_free;

   // scaling runs only once the countdown is over
   assign scale_start = req_take & (count_ff == '0);

   // reference: sample in Q.8, halfway average otherwise
   assign sample_ref = {req_sample, {REF_FRAC{1'b0}}};
   assign ref_sum    = {1'b0, ref_ff} + {1'b0, sample_ref};

   dtm_scale #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_scale (
      .clock      (clock),
      .reset      (reset),
      .start      (scale_start),
      .sample     (req_sample),
      .ref_level  (ref_ff),
      .stat       (scale_stat),
      .temperature(scale_temp)
   );

   // latched alarm; error test first, then warning, then clear
   always_comb begin
      alarm_code = ALARM_NONE;
      alarm_next = latched_ff;
      if (res_temp_ff > error_ff && !latched_ff) begin
         alarm_code = ALARM_ERROR;
         alarm_next = 1'b1;
      end else if (res_temp_ff > warn_ff && !latched_ff) begin
         alarm_code = ALARM_WARN;
         alarm_next = 1'b1;
      end else if (res_temp_ff <= warn_ff && latched_ff) begin
         alarm_code = ALARM_CLEARED;
         alarm_next = 1'b0;
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      warn_in      = warn_ff;
      error_in     = error_ff;
      count_in     = count_ff;
      ref_in       = ref_ff;
      latched_in   = latched_ff;
      res_temp_in  = res_temp_ff;
      res_cal_in   = res_cal_ff;
      res_sw_in    = res_sw_ff;
      out_valid_in = out_valid_ff & rsp_stall;
      out_temp_in  = out_temp_ff;
      out_cal_in   = out_cal_ff;
      out_sw_in    = out_sw_ff;
      out_alarm_in = out_alarm_ff;

      if (csr_write) begin
         case (csr_index)
            REG_WARN:  warn_in  = csr_pwdata[TEMP_W-1:0];
            REG_ERROR: error_in = csr_pwdata[TEMP_W-1:0];
            default:   ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (count_ff != '0) begin
                  // warm-up step: build reference, report zero
                  if (count_ff == LOAD_COUNT) begin
                     ref_in = sample_ref;
                  end else begin
                     ref_in = ref_sum[REF_W:1];
                  end
                  count_in    = count_ff - 1'b1;
                  res_temp_in = '0;
                  res_cal_in  = 1'b0;
                  res_sw_in   = (count_ff == SWITCH_COUNT);
                  state_in    = ST_DONE;
               end else begin
                  res_cal_in = 1'b1;
                  res_sw_in  = 1'b0;
                  state_in   = ST_SCALE;
               end
            end
         end
         ST_SCALE: begin
            if (scale_stat.done) begin
               res_temp_in = scale_temp;
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               out_valid_in = 1'b1;
               out_temp_in  = res_temp_ff;
               out_cal_in   = res_cal_ff;
               out_sw_in    = res_sw_ff;
               out_alarm_in = alarm_code;
               latched_in   = alarm_next;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         warn_ff      <= WARN_RESET;
         error_ff     <= ERROR_RESET;
         count_ff     <= COUNT_W'(WARMUP_STEPS);
         ref_ff       <= '0;
         latched_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         warn_ff      <= warn_in;
         error_ff     <= error_in;
         count_ff     <= count_in;
         ref_ff       <= ref_in;
         latched_ff   <= latched_in;
         out_valid_ff <= out_valid_in;
      end
      res_temp_ff  <= res_temp_in;
      res_cal_ff   <= res_cal_in;
      res_sw_ff    <= res_sw_in;
      out_temp_ff  <= out_temp_in;
      out_cal_ff   <= out_cal_in;
      out_sw_ff    <= out_sw_in;
      out_alarm_ff <= out_alarm_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_temperature    = out_temp_ff;
   assign rsp_calibrated     = out_cal_ff;
   assign rsp_switch_channel = out_sw_ff;
   assign rsp_alarm_event    = out_alarm_ff;

   // ---------------------------------------------------------------- checks
   // scaling unit only reports completion while the sequencer waits for it
   a_scale_done_in_scale: assert property (@(posedge clock) disable iff (reset)
      scale_stat.done |-> (state_ff == ST_SCALE))
      else $error("scale unit finished outside the scale phase");

   // scaling unit is busy exactly while the sequencer sits in the scale phase
   a_scale_busy_match: assert property (@(posedge clock) disable iff (reset)
      scale_stat.busy == (state_ff == ST_SCALE))
      else $error("scale unit busy out of step with the sequencer");

   // a warm-up result that requests the channel switch never claims calibration
   a_cal_excl_switch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_calibrated && rsp_switch_channel))
      else $error("calibrated and switch_channel both set");

   // countdown never runs above its start value
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(WARMUP_STEPS))
      else $error("warm-up count out of range");

   // a raised alarm leaves the latch set
   a_raise_latches: assert property (@(posedge clock) disable iff (reset)
      (out_load && (alarm_code == ALARM_ERROR || alarm_code == ALARM_WARN))
      |=> latched_ff)
      else $error("alarm raised without latching");

endmodule

`default_nettype wire

// ===== tb/die_temperature_monitor_top_tb.sv =====
// Self-checking testbench for the die temperature monitor: warm-up, scaling, alarms, registers.
`timescale 1ns / 1ps

module die_temperature_monitor_top_tb;
   import dtm_pkg::*;

   localparam int SAMPLE_W = DEF_SAMPLE_BITS;
   localparam int WARMUP = DEF_WARMUP_STEPS;
   localparam int REF_W = SAMPLE_W + 8;           // reference level, Q.8
   localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
   localparam logic [3:0] LOAD_AT = 4'd5;         // reference loaded outright
   localparam logic [3:0] SWITCH_AT = 4'd2;       // sensor channel requested
   localparam longint unsigned GAIN_Q16 = 64'd32401392;         // 1.21 * 408.6
   localparam longint unsigned TEMP_OFFSET_Q16 = 64'd18448384;  // 281.5
   localparam logic [TEMP_W-1:0] WARN_DEFAULT = 8'd75;
   localparam logic [TEMP_W-1:0] ERROR_DEFAULT = 8'd85;
   // slowest run is roughly 2k transfers; this limit leaves a wide margin
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_PAD = 48;                 // a bit more than one scaling pass
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLDOFF_CYCLES = 400;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   typedef struct {
      logic [TEMP_W-1:0] temperature;
      logic              calibrated;
      logic              switch_channel;
      alarm_type         alarm_event;
   } reading_type;

   // DUT ports, all inputs known from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [SAMPLE_W-1:0]   req_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [TEMP_W-1:0]     rsp_temperature;
   logic                  rsp_calibrated;
   logic                  rsp_switch_channel;
   logic [1:0]            rsp_alarm_event;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predictor state: mirrors the block's registers, countdown, reference and latch
   logic [TEMP_W-1:0] warn_level = WARN_DEFAULT;
   logic [TEMP_W-1:0] error_level = ERROR_DEFAULT;
   logic [3:0]        warmup_left = 4'(WARMUP);
   logic [REF_W-1:0]  ref_level = '0;
   logic              alarm_held = 1'b0;
   reading_type       pending_readings[$];

   // pacing knobs, set by the test tasks
   stall_mode_type stall_mode = STALL_NONE;
   int burst_max = 4;
   int gap_max = 0;
   int burst_left = 1;
   bit holdoff_req = 1'b0;

   // bookkeeping
   int cycle_count = 0;
   int samples_sent = 0;
   int readings_checked = 0;
   int mismatches = 0;
   int settings_used = 0;
   int alarm_seen[4] = '{0, 0, 0, 0};

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   die_temperature_monitor_top #(
      .SAMPLE_BITS (SAMPLE_W),
      .WARMUP_STEPS(WARMUP)
   ) uut (.*);

   // ---------------------------------------------------------------- predictor

   // Scaled temperature for one sample against a given reference level.
   // Quotient is Q16 volts*gain; below the offset means a negative reading.
   function automatic logic [TEMP_W-1:0] temp_from_sample(logic [SAMPLE_W-1:0] s,
                                                          logic [REF_W-1:0] refl);
      longint unsigned q;
      if (refl == '0) return 8'hFF;   // divider by zero gives all ones
      q = (64'(s) * GAIN_Q16 * 64'd256) / 64'(refl);
      if (q <= TEMP_OFFSET_Q16) return 8'h00;
      q = (q - TEMP_OFFSET_Q16) >> 16;
      return (q > 64'd255) ? 8'hFF : q[7:0];
   endfunction

   // Smallest sample that reaches the target temperature (scaling is monotonic).
   function automatic logic [SAMPLE_W-1:0] sample_for_temp(int target);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = SAMPLE_MAX;
      while (lo < hi) begin
         mid = (lo + hi) / 2;
         if (int'(temp_from_sample(SAMPLE_W'(mid), ref_level)) >= target) hi = mid;
         else lo = mid + 1;
      end
      return SAMPLE_W'(lo);
   endfunction

   // Advances the predicted state by one accepted sample and returns its reading.
   function automatic reading_type predict_reading(logic [SAMPLE_W-1:0] s);
      reading_type r;
      logic [REF_W-1:0] scaled;
      scaled = {s, 8'h00};
      r.temperature = '0;
      r.calibrated = 1'b0;
      r.switch_channel = 1'b0;
      if (warmup_left != 4'd0) begin
         if (warmup_left == LOAD_AT) ref_level = scaled;
         else ref_level = REF_W'(({1'b0, ref_level} + {1'b0, scaled}) >> 1);
         r.switch_channel = (warmup_left == SWITCH_AT);
         warmup_left = warmup_left - 4'd1;
      end else begin
         r.temperature = temp_from_sample(s, ref_level);
         r.calibrated = 1'b1;
      end
      // alarm runs on every step, warm-up included (temperature 0 there)
      if (r.temperature > error_level && !alarm_held) begin
         alarm_held = 1'b1;
         r.alarm_event = ALARM_ERROR;
      end else if (r.temperature > warn_level && !alarm_held) begin
         alarm_held = 1'b1;
         r.alarm_event = ALARM_WARN;
      end else if (r.temperature <= warn_level && alarm_held) begin
         alarm_held = 1'b0;
         r.alarm_event = ALARM_CLEARED;
      end else begin
         r.alarm_event = ALARM_NONE;
      end
      return r;
   endfunction

   // ------------------------------------------------------------ checking side

   task automatic check_field(string name, logic [TEMP_W-1:0] want, logic [TEMP_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Every rsp_ transfer is matched against the oldest pending reading.
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         readings_checked++;
         if (pending_readings.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual temperature %0d",
                     $time, rsp_temperature);
         end else begin
            want = pending_readings.pop_front();
            check_field("temperature", want.temperature, rsp_temperature);
            check_field("calibrated", TEMP_W'(want.calibrated), TEMP_W'(rsp_calibrated));
            check_field("switch_channel", TEMP_W'(want.switch_channel),
                        TEMP_W'(rsp_switch_channel));
            check_field("alarm_event", TEMP_W'(want.alarm_event), TEMP_W'(rsp_alarm_event));
            alarm_seen[want.alarm_event]++;
         end
      end
   end

   // Receiver: stall pattern per mode, plus a long hold-off counted here on request.
   always @(posedge clock) begin
      int stall_phase;
      int holdoff_left;
      if (holdoff_req) begin
         holdoff_req = 1'b0;
         holdoff_left = HOLDOFF_CYCLES;
      end
      stall_phase = (stall_phase + 1) % 9;
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 9) < 7);
            STALL_PERIODIC: rsp_stall <= (stall_phase < 4);
            default:        rsp_stall <= 1'b0;
         endcase
      end
   end

   // Watchdog: a hung handshake ends the run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still pending",
                  cycle_count, pending_readings.size());
         $display("Verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------ sending side

   // One req_ transfer; valid stays up inside a burst, drops for a random gap after it when gap_max > 0.
   task automatic send_sample(logic [SAMPLE_W-1:0] s);
      req_valid <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
      pending_readings.push_back(predict_reading(s));
      samples_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, burst_max);
         if (gap_max > 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
         end
      end
   endtask

   // Sender goes quiet until every pending reading has come back.
   task automatic wait_drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_readings.size() != 0);
      burst_left = $urandom_range(1, burst_max);
   endtask

   task automatic csr_read(reg_index_type idx, output logic [CSR_DATA_W-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      data = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_register(reg_index_type idx, logic [TEMP_W-1:0] want);
      logic [CSR_DATA_W-1:0] got;
      csr_read(idx, got);
      if (got !== CSR_DATA_W'(want)) begin
         mismatches++;
         $display("%0t: register %s readback, expected 0x%0h, actual 0x%0h",
                  $time, idx.name(), want, got);
      end
   endtask

   // Setup + access write, then read back once the bus is idle again.
   task automatic csr_write(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      // register keeps only the low byte
      if (idx == REG_WARN) warn_level = value[TEMP_W-1:0];
      else error_level = value[TEMP_W-1:0];
      @(posedge clock);
      check_register(idx, value[TEMP_W-1:0]);
   endtask

   // Thresholds change only with the block idle; upper data bits carry junk.
   task automatic set_thresholds(int warn, int err);
      wait_drain;
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(REG_WARN, {24'($urandom), 8'(warn)});
      csr_write(REG_ERROR, {24'($urandom), 8'(err)});
      settings_used++;
   endtask

   // Mostly samples aimed at the thresholds, some across the useful window, some noise.
   task automatic run_random_samples(int n);
      int pick;
      int target;
      int win;
      logic [SAMPLE_W-1:0] s;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            target = ($urandom_range(0, 1) ? int'(warn_level) : int'(error_level))
                     + int'($urandom_range(0, 6)) - 3;
            if (target < 0) target = 0;
            if (target > 255) target = 255;
            s = sample_for_temp(target);
         end else if (pick < 85) begin
            // roughly 0.55..1.1 of the reference maps onto 0..255 degrees
            win = (int'(ref_level >> 8) * int'($urandom_range(560, 1120))) >> 10;
            s = SAMPLE_W'((win > SAMPLE_MAX) ? SAMPLE_MAX : win);
         end else begin
            s = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
         end
         send_sample(s);
      end
   endtask

   // ------------------------------------------------------------------- tests

   task automatic test_register_defaults;
      check_register(REG_WARN, WARN_DEFAULT);
      check_register(REG_ERROR, ERROR_DEFAULT);
   endtask

   // Warm-up countdown: rail values and 0xAAA while averaging, load at count 5,
   // odd values after it; channel switch request at count 2.
   task automatic test_warmup;
      int unsigned warm_samples[10] = '{12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'hAAA,
                                        2000, 2001, 1999, 2003, 1997};
      stall_mode = STALL_LIGHT;
      burst_max = 3;
      gap_max = 5;
      foreach (warm_samples[i]) send_sample(SAMPLE_W'(warm_samples[i]));
   endtask

   // Alarm latch with default thresholds: negative and saturated readings, error
   // raised, held while hot, cleared exactly at warn, warning raised one above it.
   task automatic test_alarm_sequence;
      int targets[9] = '{80, 75, 76, 86, 74, 86, 85, 0, 85};
      stall_mode = STALL_NONE;
      gap_max = 0;
      send_sample('0);
      send_sample('1);
      foreach (targets[i]) send_sample(sample_for_temp(targets[i]));
   endtask

   task automatic test_default_thresholds;
      stall_mode = STALL_LIGHT;
      burst_max = 6;
      gap_max = 12;
      run_random_samples(500);
   endtask

   // Both registers at the rails, together and apart, under different pacing.
   task automatic test_threshold_extremes;
      int warns[4] = '{0, 255, 0, 255};
      int errs[4] = '{0, 255, 255, 0};
      stall_mode_type modes[4] = '{STALL_HEAVY, STALL_PERIODIC, STALL_NONE, STALL_LIGHT};
      int gaps[4] = '{0, 40, 3, 16};
      foreach (warns[i]) begin
         set_thresholds(warns[i], errs[i]);
         stall_mode = modes[i];
         gap_max = gaps[i];
         burst_max = 1 + i * 3;
         run_random_samples(200);
      end
   endtask

   // Error threshold below warn: error test still comes first.
   task automatic test_threshold_odd_order;
      set_thresholds(100, 60);
      stall_mode = STALL_PERIODIC;
      burst_max = 5;
      gap_max = 30;
      run_random_samples(250);
   endtask

   task automatic test_random_thresholds;
      repeat (4) begin
         set_thresholds($urandom_range(0, 255), $urandom_range(0, 255));
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         burst_max = $urandom_range(1, 10);
         gap_max = $urandom_range(0, 35);
         run_random_samples(80);
      end
   endtask

   // Receiver holds off long enough for the block to fill and stall req_; the
   // sender keeps offering, then pauses until everything is back.
   task automatic test_backpressure;
      set_thresholds(WARN_DEFAULT, ERROR_DEFAULT);
      stall_mode = STALL_NONE;
      gap_max = 0;
      holdoff_req = 1'b1;
      run_random_samples(10);
      wait_drain;
      stall_mode = STALL_HEAVY;
      gap_max = 8;
      run_random_samples(50);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_defaults;
      test_warmup;
      test_alarm_sequence;
      test_default_thresholds;
      test_threshold_extremes;
      test_threshold_odd_order;
      test_random_thresholds;
      test_backpressure;
      wait_drain;
      repeat (DRAIN_PAD) @(posedge clock);
      $display("Covered warm-up, alarms, %0d threshold sets, hold-off: %0d sent, %0d checked.",
               settings_used, samples_sent, readings_checked);
      $display("Alarm events seen: %0d error, %0d warning, %0d cleared; %0d mismatches.",
               alarm_seen[ALARM_ERROR], alarm_seen[ALARM_WARN], alarm_seen[ALARM_CLEARED],
               mismatches);
      if (mismatches == 0 && pending_readings.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/dtm_pkg.sv
design/dtm_scale.sv
design/die_temperature_monitor_top.sv
tb/die_temperature_monitor_top_tb.sv
